// ===== hdl/chsel_pkg.sv =====
// Shared types, codes and constants of the channel selector with drain.
package chsel_pkg;

  // Operation codes of an input item
  localparam logic [2:0] OP_SELECT   = 3'd0;
  localparam logic [2:0] OP_FAIL     = 3'd1;
  localparam logic [2:0] OP_SUCCESS  = 3'd2;
  localparam logic [2:0] OP_COMPLETE = 3'd3;
  localparam logic [2:0] OP_RECOVER  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANS  = 2'd3;

  // Routing modes
  localparam logic MODE_RR = 1'b0;
  localparam logic MODE_LL = 1'b1;

  // Register reset values and saturation limits
  localparam logic [15:0] LIMIT_RST  = 16'hFFFF;
  localparam logic [7:0]  THRESH_RST = 8'd3;
  localparam logic [7:0]  ERR_MAX    = 8'hFF;
  localparam logic [19:0] TOTAL_MAX  = 20'hFFFFF;

  // Width of the rotation counter
  localparam int ROT_W = 32;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] channel_id;
  } chsel_in_t;

  typedef struct packed {
    logic        granted;
    logic [3:0]  picked_channel;
    logic        drain_marked;
    logic [1:0]  status;
    logic [19:0] total_inflight;
  } chsel_out_t;

  // One channel table entry
  typedef struct packed {
    logic        draining;
    logic [7:0]  errors;
    logic [15:0] inflight;
  } chsel_entry_t;

  localparam int ENTRY_W = $bits(chsel_entry_t);

  // Controller to datapath commands
  typedef struct packed {
    logic latch_in;
    logic pass_start;
    logic pass_pick;
    logic mod_start;
    logic commit;
  } chsel_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pass_done;
    logic mod_done;
    logic need_mod;
    logic out_free;
  } chsel_stat_t;

endpackage

// ===== hdl/chsel_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module chsel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/chsel_mod.sv =====
// Bit-serial remainder unit: rotation counter modulo the active channel count.
module chsel_mod #(
  parameter int DIV_W = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [chsel_pkg::ROT_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]            divisor_i,
  output logic                        done_o,
  output logic [DIV_W-1:0]            rem_o
);

  localparam int CNT_W = $clog2(chsel_pkg::ROT_W);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [chsel_pkg::ROT_W-1:0] dvd_q, dvd_d;
  logic [DIV_W-1:0]            div_q, div_d;
  logic [DIV_W-1:0]            rem_q, rem_d;
  logic [DIV_W:0]              trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[chsel_pkg::ROT_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(chsel_pkg::ROT_W - 1);
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // restoring step: one dividend bit a cycle, remainder stays below divisor
      if (trial >= {1'b0, div_q}) begin
        rem_d = DIV_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = DIV_W'(trial);
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== hdl/chsel_dp.sv =====
// Datapath: configuration, channel table, scan passes, update and result register.
module chsel_dp #(
  parameter int CHANNELS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [chsel_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [chsel_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  chsel_pkg::chsel_in_t             in_data_i,
  input  chsel_pkg::chsel_cmd_t            cmd_i,
  output chsel_pkg::chsel_stat_t           stat_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output chsel_pkg::chsel_out_t            out_data_o
);

  localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW     = $clog2(CHANNELS + 1);
  localparam int XW     = (CW > 4) ? CW : 4;
  localparam int SW_RAW = 17 + $clog2(CHANNELS);
  localparam int SW     = (SW_RAW > 21) ? SW_RAW : 21;

  // configuration
  logic        mode_q;
  logic [15:0] limit_q;
  logic [7:0]  thresh_q;
  logic [4:0]  chans_q;

  chsel_pkg::chsel_in_t in_q;
  logic [chsel_pkg::ROT_W-1:0] rot_q;
  logic [CHANNELS-1:0] valid_q;

  // scan pass
  logic          pass_act_q, pick_q, rd_vld_q, vbit_q;
  logic [CW-1:0] idx_q, act_cnt_q, rank_q;
  logic [AW-1:0] rd_idx_q;
  logic [SW-1:0] sum_q;
  chsel_pkg::chsel_entry_t tgt_q, a_word_q, b_word_q;
  logic          a_found_q, b_found_q;
  logic [AW-1:0] a_idx_q, b_idx_q;

  logic                  out_vld_q;
  chsel_pkg::chsel_out_t out_q;

  logic [CW-1:0] live_n, start_w;
  logic          issue, pass_done, mod_done, elig, ch_ok, bad, tgt_hit, need_mod;
  logic [chsel_pkg::ENTRY_W-1:0] ram_rdata;
  chsel_pkg::chsel_entry_t rd_e, sel_word, wr_word;
  logic [AW-1:0] sel_idx, wr_addr;
  logic          pick_found, wr_en, inc;
  logic [15:0]   dec;
  logic [SW-1:0] sum_adj;
  chsel_pkg::chsel_out_t res;

  assign live_n    = (32'(chans_q) > CHANNELS) ? CW'(CHANNELS) : CW'(chans_q);
  assign issue     = pass_act_q && (idx_q < live_n);
  assign pass_done = pass_act_q && !issue && !rd_vld_q;

  // never-written entries read as the reset value
  assign rd_e    = vbit_q ? chsel_pkg::chsel_entry_t'(ram_rdata) : '0;
  assign elig    = !rd_e.draining && (rd_e.inflight < limit_q);
  assign ch_ok   = XW'(in_q.channel_id) < XW'(live_n);
  assign bad     = (in_q.op > chsel_pkg::OP_RECOVER) || !ch_ok;
  assign tgt_hit = XW'(rd_idx_q) == XW'(in_q.channel_id);
  assign need_mod = (in_q.op == chsel_pkg::OP_SELECT) && (mode_q == chsel_pkg::MODE_RR) &&
                    (act_cnt_q != '0);

  chsel_ram #(
    .WIDTH (chsel_pkg::ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_word),
    .re_i    (issue),
    .raddr_i (AW'(idx_q)),
    .rdata_o (ram_rdata)
  );

  chsel_mod #(
    .DIV_W (CW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (rot_q),
    .divisor_i  (act_cnt_q),
    .done_o     (mod_done),
    .rem_o      (start_w)
  );

  // update of the chosen entry and the result
  always_comb begin
    pick_found = (mode_q == chsel_pkg::MODE_LL) ? a_found_q : (a_found_q || b_found_q);
    sel_idx    = ((mode_q == chsel_pkg::MODE_LL) || a_found_q) ? a_idx_q : b_idx_q;
    sel_word   = ((mode_q == chsel_pkg::MODE_LL) || a_found_q) ? a_word_q : b_word_q;
    wr_en      = 1'b0;
    wr_addr    = sel_idx;
    wr_word    = sel_word;
    inc        = 1'b0;
    dec        = '0;
    res        = '0;
    if (in_q.op == chsel_pkg::OP_SELECT) begin
      if (pick_found) begin
        wr_en              = 1'b1;
        wr_word.inflight   = sel_word.inflight + 16'd1;
        inc                = 1'b1;
        res.granted        = 1'b1;
        res.picked_channel = 4'(sel_idx);
      end else begin
        res.status = chsel_pkg::ST_NONE;
      end
    end else if (bad) begin
      res.status = chsel_pkg::ST_IGNORED;
    end else begin
      wr_addr = AW'(in_q.channel_id);
      wr_word = tgt_q;
      case (in_q.op)
        chsel_pkg::OP_FAIL: begin
          wr_en = 1'b1;
          if (tgt_q.errors != chsel_pkg::ERR_MAX) begin
            wr_word.errors = tgt_q.errors + 8'd1;
          end
          if ((wr_word.errors >= thresh_q) && !tgt_q.draining) begin
            wr_word.draining = 1'b1;
            res.drain_marked = 1'b1;
          end
        end
        chsel_pkg::OP_SUCCESS: begin
          wr_en          = 1'b1;
          wr_word.errors = '0;
        end
        chsel_pkg::OP_COMPLETE: begin
          if (tgt_q.inflight != '0) begin
            wr_en            = 1'b1;
            dec              = 16'd1;
            wr_word.inflight = tgt_q.inflight - 16'd1;
          end
        end
        chsel_pkg::OP_RECOVER: begin
          if (tgt_q.draining) begin
            wr_en   = 1'b1;
            dec     = tgt_q.inflight;
            wr_word = '0;
          end
        end
        default: begin
          res.status = chsel_pkg::ST_IGNORED;
        end
      endcase
    end
    // total after the step: pre-step sum plus this step's change, saturated
    sum_adj = sum_q + SW'(inc) - SW'(dec);
    res.total_inflight = (sum_adj > SW'(chsel_pkg::TOTAL_MAX)) ? chsel_pkg::TOTAL_MAX :
                         sum_adj[19:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= chsel_pkg::MODE_RR;
      limit_q   <= chsel_pkg::LIMIT_RST;
      thresh_q  <= chsel_pkg::THRESH_RST;
      chans_q   <= '0;
      rot_q     <= '0;
      valid_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          chsel_pkg::CFG_MODE:   mode_q   <= cfg_wdata_i[0];
          chsel_pkg::CFG_LIMIT:  limit_q  <= cfg_wdata_i;
          chsel_pkg::CFG_THRESH: thresh_q <= cfg_wdata_i[7:0];
          chsel_pkg::CFG_CHANS:  chans_q  <= cfg_wdata_i[4:0];
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        out_vld_q <= 1'b1;
        if (need_mod) begin
          rot_q <= rot_q + 1'b1;
        end
        if (wr_en) begin
          valid_q[wr_addr] <= 1'b1;
        end
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_act_q <= 1'b0;
      pick_q     <= 1'b0;
      rd_vld_q   <= 1'b0;
      idx_q      <= '0;
      a_found_q  <= 1'b0;
      b_found_q  <= 1'b0;
      act_cnt_q  <= '0;
      rank_q     <= '0;
    end else begin
      if (pass_act_q) begin
        rd_vld_q <= issue;
        if (issue) begin
          idx_q <= idx_q + 1'b1;
        end
        if (pass_done) begin
          pass_act_q <= 1'b0;
        end
      end
      if (rd_vld_q) begin
        if (!pick_q) begin
          if (!rd_e.draining) begin
            act_cnt_q <= act_cnt_q + 1'b1;
          end
          if (elig && (!a_found_q || (rd_e.inflight < a_word_q.inflight))) begin
            a_found_q <= 1'b1;
          end
        end else if (!rd_e.draining) begin
          rank_q <= rank_q + 1'b1;
          if (elig && !a_found_q && (rank_q >= start_w)) begin
            a_found_q <= 1'b1;
          end
          if (elig && !b_found_q) begin
            b_found_q <= 1'b1;
          end
        end
      end
      if (cmd_i.pass_start) begin
        pass_act_q <= 1'b1;
        pick_q     <= cmd_i.pass_pick;
        rd_vld_q   <= 1'b0;
        idx_q      <= '0;
        a_found_q  <= 1'b0;
        b_found_q  <= 1'b0;
        rank_q     <= '0;
        if (!cmd_i.pass_pick) begin
          act_cnt_q <= '0;
        end
      end
    end
  end

  // payload registers of the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      in_q <= in_data_i;
    end
    if (issue) begin
      rd_idx_q <= AW'(idx_q);
      vbit_q   <= valid_q[AW'(idx_q)];
    end
    if (cmd_i.pass_start && !cmd_i.pass_pick) begin
      sum_q <= '0;
    end else if (rd_vld_q && !pick_q) begin
      sum_q <= sum_q + SW'(rd_e.inflight);
    end
    if (rd_vld_q) begin
      if (!pick_q) begin
        if (tgt_hit) begin
          tgt_q <= rd_e;
        end
        if (elig && (!a_found_q || (rd_e.inflight < a_word_q.inflight))) begin
          a_idx_q  <= rd_idx_q;
          a_word_q <= rd_e;
        end
      end else if (!rd_e.draining) begin
        if (elig && !a_found_q && (rank_q >= start_w)) begin
          a_idx_q  <= rd_idx_q;
          a_word_q <= rd_e;
        end
        if (elig && !b_found_q) begin
          b_idx_q  <= rd_idx_q;
          b_word_q <= rd_e;
        end
      end
    end
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  assign stat_o.pass_done = pass_done;
  assign stat_o.mod_done  = mod_done;
  assign stat_o.need_mod  = need_mod;
  assign stat_o.out_free  = !out_vld_q || !out_stall_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/chsel_ctrl.sv =====
// Controller: sequences the scan passes, the remainder unit and the commit of one item.
module chsel_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  chsel_pkg::chsel_stat_t stat_i,
  output chsel_pkg::chsel_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PRE    = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_PICK   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in   = 1'b1;
          cmd_o.pass_start = 1'b1;
          state_d          = S_PRE;
        end
      end
      S_PRE: begin
        if (stat_i.pass_done) begin
          if (stat_i.need_mod) begin
            cmd_o.mod_start = 1'b1;
            state_d         = S_MOD;
          end else begin
            state_d = S_COMMIT;
          end
        end
      end
      S_MOD: begin
        if (stat_i.mod_done) begin
          cmd_o.pass_start = 1'b1;
          cmd_o.pass_pick  = 1'b1;
          state_d          = S_PICK;
        end
      end
      S_PICK: begin
        if (stat_i.pass_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // hold until the result register can take the item
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/channel_selector_with_drain_unit.sv =====
// Top level of the channel selector with drain: controller plus datapath.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one request item:
//   select, failure, success, completion or recover, with a target channel.
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns exactly one
//   result item per request: grant, picked channel, drain mark, status and total
//   in-flight count over the live channels.
//   Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i); write
//   it only while no request is outstanding.
// Operation (n = live channels, min of channels_in_use and CHANNELS):
//   one scan of the table memory, one entry a cycle over the n live entries,
//   gives the result; a round-robin select with an active channel also runs the
//   bit-serial remainder and a second scan. One item is in work at a
//   time; the next is accepted the cycle after the previous one is committed.
// Reset: the table reads as all active with zero counts (per-entry valid bits),
//   the rotation counter is zero and the registers take their reset values.
//   No clearing pass is needed.
// Stall: a finished result waits in the output register; a further item may be
//   accepted and worked on, and holds before commit until that register frees.
module channel_selector_with_drain_unit #(
  parameter int CHANNELS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  chsel_pkg::chsel_in_t             in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output chsel_pkg::chsel_out_t            out_data_o,
  input  logic                             cfg_we_i,
  input  logic [chsel_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [chsel_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  // command and status between the sequencer and the datapath
  chsel_pkg::chsel_cmd_t  cmd;
  chsel_pkg::chsel_stat_t stat;

  // sequencer: accept, scan, optional remainder and pick scan, commit
  chsel_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: registers, channel table, scan logic and result register
  chsel_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== dv/channel_selector_with_drain_unit_tb.sv =====
// Self-checking testbench of the channel selector with drain: table, random traffic, checks.
`timescale 1ns / 1ps

module channel_selector_with_drain_unit_tb;
  import chsel_pkg::*;

  localparam int CHANNELS     = 16;
  // Margin for the slowest item: round-robin select on a full table
  localparam int SETTLE_TICKS = 2 * CHANNELS + 48;
  localparam int QUIET_LIMIT  = 5000;
  localparam int PHASE_ITEMS  = 375;
  localparam int RESHUFFLE_AT = 125;
  localparam int HOLD_TICKS   = 300;

  // Undefined operation codes, kept apart from the package codes
  localparam logic [2:0] OP_BAD_LO = 3'd5;
  localparam logic [2:0] OP_BAD_HI = 3'd7;

  typedef struct {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    chsel_in_t             item;
    logic                  known;
    chsel_out_t            reply;
  } plan_row_t;

  // Block ports
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  chsel_in_t             in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  chsel_out_t            out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Hand-typed expectation that travels with the item on the input channel
  logic                  known_on = 1'b0;
  chsel_out_t            known_reply = '0;

  // Own copy of the channel table, rotation counter and registers
  logic                  tbl_draining [CHANNELS];
  logic [15:0]           tbl_inflight [CHANNELS];
  logic [7:0]            tbl_errors   [CHANNELS];
  logic [ROT_W-1:0]      rr_count;
  logic                  mode_q;
  logic [15:0]           limit_q;
  logic [7:0]            thresh_q;
  logic [4:0]            nchan_q;

  chsel_out_t            replies_due [$];
  int                    bad_replies = 0;
  int                    quiet_cycles = 0;

  // Idle rates in percent of cycles, and the receiver's long hold-off
  int                    tx_pct = 0;
  int                    rx_pct = 0;
  int                    hold_req = 0;
  int                    hold_left = 0;
  int                    cur_live = 0;

  plan_row_t             plan [$];

  channel_selector_with_drain_unit #(
    .CHANNELS(CHANNELS)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Work out the result of one request and advance the table copy.
  function automatic chsel_out_t route_request(chsel_in_t it);
    chsel_out_t  r;
    int unsigned live, total, start, sum;
    int unsigned roster [CHANNELS];
    int          pick;
    logic [3:0]  c;
    r     = '0;
    live  = (nchan_q < CHANNELS) ? nchan_q : CHANNELS;
    c     = it.channel_id;
    pick  = -1;
    total = 0;
    if (it.op == OP_SELECT) begin
      if (mode_q == MODE_LL) begin
        // Lowest index wins a tie, so only a strictly smaller load replaces
        for (int i = 0; i < live; i++) begin
          if (!tbl_draining[i] && tbl_inflight[i] < limit_q &&
              (pick < 0 || tbl_inflight[i] < tbl_inflight[pick])) begin
            pick = i;
          end
        end
      end else begin
        for (int i = 0; i < live; i++) begin
          if (!tbl_draining[i]) begin
            roster[total] = i;
            total++;
          end
        end
        // An empty roster leaves the rotation counter where it is
        if (total != 0) begin
          start = rr_count % total;
          rr_count++;
          for (int k = 0; k < total && pick < 0; k++) begin
            if (tbl_inflight[roster[(start + k) % total]] < limit_q) begin
              pick = roster[(start + k) % total];
            end
          end
        end
      end
      if (pick < 0) begin
        r.status = ST_NONE;
      end else begin
        tbl_inflight[pick]++;
        r.granted        = 1'b1;
        r.picked_channel = pick[3:0];
        r.status         = ST_OK;
      end
    end else if (it.op > OP_RECOVER || c >= live) begin
      r.status = ST_IGNORED;
    end else begin
      case (it.op)
        OP_FAIL: begin
          // Errors keep counting on a draining channel, up to saturation
          if (tbl_errors[c] != ERR_MAX) tbl_errors[c]++;
          if (tbl_errors[c] >= thresh_q && !tbl_draining[c]) begin
            tbl_draining[c] = 1'b1;
            r.drain_marked  = 1'b1;
          end
        end
        OP_SUCCESS: tbl_errors[c] = '0;
        OP_COMPLETE: begin
          if (tbl_inflight[c] != 0) tbl_inflight[c]--;
        end
        default: begin
          if (tbl_draining[c]) begin
            tbl_draining[c] = 1'b0;
            tbl_inflight[c] = '0;
            tbl_errors[c]   = '0;
          end
        end
      endcase
      r.status = ST_OK;
    end
    sum = 0;
    for (int i = 0; i < live; i++) sum += tbl_inflight[i];
    r.total_inflight = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[19:0];
    return r;
  endfunction

  // Watch both channels and the register port at every edge: predict on each
  // accepted request, check each accepted result, and trip the watchdog.
  always @(posedge clk) begin
    chsel_out_t want;
    chsel_out_t got;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MODE:  mode_q   = cfg_wdata[0];
          CFG_LIMIT: limit_q  = cfg_wdata[15:0];
          CFG_THRESH: thresh_q = cfg_wdata[7:0];
          default:   nchan_q  = cfg_wdata[4:0];
        endcase
      end
      if (in_valid && !in_stall) begin
        want = route_request(in_data);
        // A typed-in expectation replaces the predicted one for that row
        replies_due.insert(replies_due.size(), known_on ? known_reply : want);
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (replies_due.size() == 0) begin
          bad_replies++;
          if (bad_replies <= 10)
            $display("%0t: result with nothing awaited: granted=%0d ch=%0d drain=%0d",
                     $realtime, got.granted, got.picked_channel, got.drain_marked,
                     " st=%0d total=%0d", got.status, got.total_inflight);
        end else begin
          want = replies_due.pop_front();
          if (got.granted !== want.granted || got.picked_channel !== want.picked_channel ||
              got.drain_marked !== want.drain_marked || got.status !== want.status ||
              got.total_inflight !== want.total_inflight) begin
            bad_replies++;
            if (bad_replies <= 10) begin
              $display("%0t: expected granted=%0d ch=%0d drain=%0d st=%0d total=%0d",
                       $realtime, want.granted, want.picked_channel, want.drain_marked,
                       want.status, want.total_inflight);
              $display("%0t: actual   granted=%0d ch=%0d drain=%0d st=%0d total=%0d",
                       $realtime, got.granted, got.picked_channel, got.drain_marked,
                       got.status, got.total_inflight);
            end
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  // Receiver: stall at the current rate, or hold off for a counted stretch.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  // Offer one item, after a random idle gap, and hold it until accepted.
  task automatic offer(chsel_in_t it, logic known, chsel_out_t reply);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_data     <= it;
    known_on    <= known;
    known_reply <= reply;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, let the last accepted item reach the list, wait for every
  // awaited result, then let the block go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Pick a fresh register setting, extremes included; upper bits of the
  // narrow registers are sometimes junk, which the block must drop.
  task automatic reshuffle();
    logic [15:0] lim;
    logic [7:0]  thr;
    logic [4:0]  nch;
    logic [15:0] junk;
    case ($urandom_range(5))
      0:       lim = 16'd1;
      1:       lim = 16'd2;
      2:       lim = 16'($urandom_range(6, 3));
      3:       lim = LIMIT_RST;
      4:       lim = 16'($urandom);
      default: lim = 16'd0;
    endcase
    case ($urandom_range(3))
      0:       thr = 8'd1;
      1:       thr = 8'($urandom_range(4, 2));
      2:       thr = ERR_MAX;
      default: thr = 8'($urandom);
    endcase
    case ($urandom_range(4))
      0:       nch = 5'd1;
      1:       nch = 5'($urandom_range(5, 2));
      2:       nch = 5'd16;
      3:       nch = 5'($urandom_range(31, 17));
      default: nch = 5'($urandom_range(31));
    endcase
    junk = $urandom_range(1) ? 16'($urandom) : 16'd0;
    settle();
    write_reg(CFG_MODE, {junk[15:1], 1'($urandom_range(1))});
    write_reg(CFG_LIMIT, lim);
    write_reg(CFG_THRESH, {junk[15:8], thr});
    write_reg(CFG_CHANS, {junk[15:5], nch});
    cur_live = (nch < CHANNELS) ? nch : CHANNELS;
  endtask

  // Mostly live targets; now and then any index, which may be out of the table.
  function automatic logic [3:0] aim();
    if (cur_live != 0 && $urandom_range(99) < 85) return 4'($urandom_range(cur_live - 1));
    return 4'($urandom_range(15));
  endfunction

  // One random phase: bursts of failures on one channel, mixed traffic, a long
  // receiver hold-off in the first phase, and a full drain midway if no burst steps over it.
  task automatic random_phase(int phase);
    int          sent;
    int          roll;
    int          len;
    logic [3:0]  ch;
    chsel_in_t   it;
    logic        held;
    sent = 0;
    held = 1'b0;
    while (sent < PHASE_ITEMS) begin
      if (sent % RESHUFFLE_AT == 0) reshuffle();
      // A burst may step over the mark, so start the hold-off once past it
      if (phase == 0 && !held && sent >= 60) begin
        hold_req = HOLD_TICKS;
        held     = 1'b1;
      end
      if (sent == 200) settle();
      roll = $urandom_range(99);
      it.channel_id = aim();
      if (roll < 92) begin
        if (roll < 40)      it.op = OP_SELECT;
        else if (roll < 55) it.op = OP_COMPLETE;
        else if (roll < 70) it.op = OP_FAIL;
        else if (roll < 80) it.op = OP_SUCCESS;
        else                it.op = OP_RECOVER;
        offer(it, 1'b0, '0);
        sent++;
      end else if (roll < 96) begin
        // A long enough burst pushes the error count into saturation
        ch  = it.channel_id;
        len = $urandom_range(3) == 0 ? $urandom_range(300, 260) : $urandom_range(40, 2);
        it.op = OP_FAIL;
        for (int b = 0; b < len; b++) begin
          it.channel_id = ch;
          offer(it, 1'b0, '0);
        end
        sent += len;
      end else begin
        it.op = 3'($urandom_range(OP_BAD_HI, OP_BAD_LO));
        offer(it, 1'b0, '0);
        sent++;
      end
    end
  endtask

  function automatic plan_row_t req_row(logic [2:0] op, logic [3:0] ch);
    plan_row_t r;
    r = '{is_cfg: 1'b0, reg_idx: '0, reg_val: '0, item: '0, known: 1'b0, reply: '0};
    r.item.op         = op;
    r.item.channel_id = ch;
    return r;
  endfunction

  function automatic plan_row_t known_row(logic [2:0] op, logic [3:0] ch, chsel_out_t reply);
    plan_row_t r;
    r       = req_row(op, ch);
    r.known = 1'b1;
    r.reply = reply;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r         = req_row(OP_SELECT, 4'd0);
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Append one row to the end of the stimulus table.
  task automatic queue_row(plan_row_t r);
    plan.insert(plan.size(), r);
  endtask

  initial begin
    // Table copy and registers as they come out of reset
    for (int i = 0; i < CHANNELS; i++) begin
      tbl_draining[i] = 1'b0;
      tbl_inflight[i] = '0;
      tbl_errors[i]   = '0;
    end
    rr_count = '0;
    mode_q   = MODE_RR;
    limit_q  = LIMIT_RST;
    thresh_q = THRESH_RST;
    nchan_q  = '0;

    // Empty table after reset: nothing to grant, every target is out of range
    queue_row(known_row(OP_SELECT, 4'd0, chsel_out_t'{1'b0, 4'd0, 1'b0, ST_NONE, 20'd0}));
    queue_row(known_row(OP_FAIL, 4'd0, chsel_out_t'{1'b0, 4'd0, 1'b0, ST_IGNORED, 20'd0}));
    queue_row(known_row(OP_BAD_HI, 4'd15,
                        chsel_out_t'{1'b0, 4'd0, 1'b0, ST_IGNORED, 20'd0}));
    // Four channels, two in flight each at most, drain on the second error
    queue_row(reg_row(CFG_CHANS, 16'd4));
    queue_row(reg_row(CFG_LIMIT, 16'd2));
    queue_row(reg_row(CFG_THRESH, 16'd2));
    queue_row(known_row(OP_SELECT, 4'd9, chsel_out_t'{1'b1, 4'd0, 1'b0, ST_OK, 20'd1}));
    queue_row(known_row(OP_SELECT, 4'd0, chsel_out_t'{1'b1, 4'd1, 1'b0, ST_OK, 20'd2}));
    queue_row(req_row(OP_SELECT, 4'd0));
    queue_row(req_row(OP_FAIL, 4'd1));
    queue_row(req_row(OP_FAIL, 4'd1));     // threshold reached, channel drains
    queue_row(req_row(OP_FAIL, 4'd1));     // keeps counting while draining
    queue_row(req_row(OP_SELECT, 4'd0));   // scan skips the draining channel
    queue_row(req_row(OP_SUCCESS, 4'd1));
    queue_row(req_row(OP_RECOVER, 4'd1));  // draining back to active, counts cleared
    queue_row(req_row(OP_RECOVER, 4'd0));  // active channel: no change
    queue_row(req_row(OP_COMPLETE, 4'd0));
    queue_row(req_row(OP_COMPLETE, 4'd3)); // in-flight already zero
    queue_row(req_row(OP_FAIL, 4'd15));    // target beyond the table
    queue_row(req_row(OP_BAD_LO, 4'd2));
    // Least loaded with a zero limit: nothing is ever eligible
    queue_row(reg_row(CFG_MODE, 16'(MODE_LL)));
    queue_row(reg_row(CFG_LIMIT, 16'd0));
    queue_row(req_row(OP_SELECT, 4'd0));
    // Oversized channel count clips to the full table
    queue_row(reg_row(CFG_LIMIT, LIMIT_RST));
    queue_row(reg_row(CFG_CHANS, 16'd31));
    queue_row(reg_row(CFG_THRESH, 16'(ERR_MAX)));
    queue_row(req_row(OP_SELECT, 4'd0));
    queue_row(req_row(OP_SELECT, 4'd0));
    queue_row(req_row(OP_FAIL, 4'd15));
    queue_row(req_row(OP_COMPLETE, 4'd15));
    // Shrink the table, then let the upper entries exist again
    queue_row(reg_row(CFG_CHANS, 16'd2));
    queue_row(req_row(OP_SELECT, 4'd0));
    queue_row(req_row(OP_RECOVER, 4'd3));
    queue_row(reg_row(CFG_CHANS, 16'd16));
    queue_row(req_row(OP_SELECT, 4'd0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        offer(plan[i].item, plan[i].known, plan[i].reply);
      end
    end
    cur_live = CHANNELS;

    // Sender idles lightly and receiver heavily, then the other way round,
    // then both run flat out
    tx_pct = 23;
    rx_pct = 51;
    random_phase(0);
    settle();
    tx_pct = 51;
    rx_pct = 23;
    random_phase(1);
    settle();
    tx_pct = 0;
    rx_pct = 0;
    random_phase(2);
    settle();

    if (bad_replies == 0 && replies_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/chsel_pkg.sv
hdl/chsel_ram.sv
hdl/chsel_mod.sv
hdl/chsel_dp.sv
hdl/chsel_ctrl.sv
hdl/channel_selector_with_drain_unit.sv
dv/channel_selector_with_drain_unit_tb.sv
